/* design/dtl_pkg.sv */
// Shared constants, types, microcode program and helpers of the dedup table unit.
package dtl_pkg;

    // Table geometry
    localparam int ENTRIES_PER_KIND = 16;
    localparam int SHAPE_KINDS      = 3;
    localparam int TOTAL_ENTRIES    = ENTRIES_PER_KIND * SHAPE_KINDS;
    localparam int ADDR_W           = $clog2(TOTAL_ENTRIES);
    localparam int IDX_W            = $clog2(ENTRIES_PER_KIND);
    localparam int KIND_W           = 2;
    localparam int WORD_W           = 32;
    localparam int KEY_W            = 3 * WORD_W;

    // Stream widths
    localparam int S_TDATA_W = ((KEY_W + IDX_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1 + KIND_W;
    localparam int M_TDATA_W = 8;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_FREE_RELEASE = 2'd2,
        ST_NEG_KEY      = 2'd3
    } status_t;

    // Operation codes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Datapath actions driven by a control word
    typedef enum logic [2:0] {
        A_NONE      = 3'd0,
        A_ACCEPT    = 3'd1,
        A_SCAN_INIT = 3'd2,
        A_SCAN      = 3'd3,
        A_RESOLVE   = 3'd4,
        A_ERR       = 3'd5,
        A_RELEASE   = 3'd6
    } action_t;

    // Branch conditions
    typedef enum logic [2:0] {
        C_IN_VALID  = 3'd0,
        C_RELEASE   = 3'd1,
        C_ACQ_ERR   = 3'd2,
        C_SCAN_MORE = 3'd3,
        C_OUT_BUSY  = 3'd4
    } cond_t;

    // Program steps
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_DISPATCH = 3'd1;
    localparam step_t STEP_CHECK    = 3'd2;
    localparam step_t STEP_SCAN     = 3'd3;
    localparam step_t STEP_RESOLVE  = 3'd4;
    localparam step_t STEP_ERR      = 3'd5;
    localparam step_t STEP_REL      = 3'd6;

    // One control word: action, branch condition, target when taken, target otherwise
    typedef struct packed {
        action_t action;
        cond_t   cond;
        step_t   jump;
        step_t   next;
    } ctrl_word_t;

    // Condition flags from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic is_release;
        logic acq_err;
        logic scan_more;
        logic out_busy;
    } flags_t;

    // Microcode ROM
    function automatic ctrl_word_t program_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE:     w = '{A_ACCEPT,    C_IN_VALID,  STEP_DISPATCH, STEP_IDLE};
            STEP_DISPATCH: w = '{A_NONE,      C_RELEASE,   STEP_REL,      STEP_CHECK};
            STEP_CHECK:    w = '{A_SCAN_INIT, C_ACQ_ERR,   STEP_ERR,      STEP_SCAN};
            STEP_SCAN:     w = '{A_SCAN,      C_SCAN_MORE, STEP_SCAN,     STEP_RESOLVE};
            STEP_RESOLVE:  w = '{A_RESOLVE,   C_OUT_BUSY,  STEP_RESOLVE,  STEP_IDLE};
            STEP_ERR:      w = '{A_ERR,       C_OUT_BUSY,  STEP_ERR,      STEP_IDLE};
            STEP_REL:      w = '{A_RELEASE,   C_OUT_BUSY,  STEP_REL,      STEP_IDLE};
            default:       w = '{A_NONE,      C_IN_VALID,  STEP_IDLE,     STEP_IDLE};
        endcase
        return w;
    endfunction

    // Flat table address of one entry of one kind
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [KIND_W-1:0] kind,
                                                     input logic [IDX_W-1:0]  idx);
        return ADDR_W'(ADDR_W'(kind) * ADDR_W'(ENTRIES_PER_KIND) + ADDR_W'(idx));
    endfunction

    // Key word fails "x >= 0" as a single: NaN, or negative nonzero
    function automatic logic key_negative(input logic [WORD_W-1:0] bits);
        logic [WORD_W-2:0] mag;
        mag = bits[WORD_W-2:0];
        return (mag > 31'h7F80_0000) || (bits[WORD_W-1] && (mag != '0));
    endfunction

endpackage

/* design/dtl_seq.sv */
// Microcode sequencer: step counter, program ROM and conditional branch.
module dtl_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  dtl_pkg::flags_t     flags,
    output dtl_pkg::ctrl_word_t ctrl
);

    dtl_pkg::step_t pc_reg;
    dtl_pkg::step_t pc_next;
    logic           taken;

    assign ctrl = dtl_pkg::program_rom(pc_reg);

    // Branch condition select
    always_comb begin
        case (ctrl.cond)
            dtl_pkg::C_IN_VALID:  taken = flags.in_valid;
            dtl_pkg::C_RELEASE:   taken = flags.is_release;
            dtl_pkg::C_ACQ_ERR:   taken = flags.acq_err;
            dtl_pkg::C_SCAN_MORE: taken = flags.scan_more;
            dtl_pkg::C_OUT_BUSY:  taken = flags.out_busy;
            default:              taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.jump : ctrl.next;
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= dtl_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* design/dedup_table_with_lowest_free_slot_unit.sv */
// Top level of the deduplicating shape table with lowest-free-entry allocation.
// Three tables of sixteen entries each hold 96-bit keys in one key memory (one write port,
// one registered read port) plus a flip-flop valid bit per entry, cleared at reset. One item
// is worked at a time by a microcoded sequencer. A release goes from acceptance through its
// dispatch step to its release step; an acquire goes through dispatch and a check step, then
// to an error step for a bad kind or negative key, or else to the scan and a resolve step.
// The scan reads one key per cycle from the memory port and stops at the first match. The result
// sits in an output register, so the next item is taken while it still waits on m_tready; a new
// result waits in its commit step until that register is free.
module dedup_table_with_lowest_free_slot_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input transactions
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dtl_pkg::S_TDATA_W-1:0]  s_tdata,  // key_x, key_y, key_z, entry_index
    input  logic [dtl_pkg::S_TUSER_W-1:0]  s_tuser,  // op, shape_kind
    // result transactions
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dtl_pkg::M_TDATA_W-1:0]  m_tdata   // slot, hit, status
);

    localparam int KW = dtl_pkg::KIND_W;
    localparam int IW = dtl_pkg::IDX_W;
    localparam int AW = dtl_pkg::ADDR_W;

    dtl_pkg::ctrl_word_t ctrl;
    dtl_pkg::flags_t     flags;

    // Latched item
    logic                      op_reg;
    logic [KW-1:0]             kind_reg;
    logic [dtl_pkg::KEY_W-1:0] key_reg;
    logic [IW-1:0]             idx_reg;

    // Table state
    logic [dtl_pkg::TOTAL_ENTRIES-1:0] valid_reg, valid_next;
    logic [dtl_pkg::KEY_W-1:0]         key_mem [dtl_pkg::TOTAL_ENTRIES];
    logic [dtl_pkg::KEY_W-1:0]         rd_data_reg;

    // Scan state
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] found_idx_reg, found_idx_next;
    logic          have_free_reg, have_free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    // Output register
    logic            m_tvalid_reg, m_tvalid_next;
    logic [IW-1:0]   slot_reg, slot_next;
    logic            hit_reg, hit_next;
    dtl_pkg::status_t status_reg, status_next;

    logic          in_fire;
    logic          out_free;
    logic          commit;
    logic          kind_ok;
    logic          idx_ok;
    logic          rel_valid;
    logic [AW-1:0] rel_addr;
    logic [AW-1:0] scan_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          mem_we;
    logic          entry_valid_now;
    logic          match_now;
    logic          last_now;

    dtl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // Handshake
    assign s_tready = (ctrl.action == dtl_pkg::A_ACCEPT);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = out_free && ((ctrl.action == dtl_pkg::A_RESOLVE) ||
                                   (ctrl.action == dtl_pkg::A_ERR) ||
                                   (ctrl.action == dtl_pkg::A_RELEASE));

    // Item checks and scan compare
    always_comb begin
        kind_ok         = int'(kind_reg) < dtl_pkg::SHAPE_KINDS;
        idx_ok          = int'(idx_reg) < dtl_pkg::ENTRIES_PER_KIND;
        rel_addr        = dtl_pkg::entry_addr(kind_reg, idx_reg);
        rel_valid       = kind_ok && idx_ok && valid_reg[rel_addr];
        scan_addr       = dtl_pkg::entry_addr(kind_reg, cmp_idx_reg);
        entry_valid_now = valid_reg[scan_addr];
        match_now       = entry_valid_now && (rd_data_reg == key_reg);
        last_now        = (cmp_idx_reg == IW'(dtl_pkg::ENTRIES_PER_KIND - 1));
    end

    // Flags to sequencer
    always_comb begin
        flags.in_valid   = s_tvalid;
        flags.is_release = (op_reg == dtl_pkg::OP_RELEASE);
        flags.acq_err    = !kind_ok || dtl_pkg::key_negative(key_reg[dtl_pkg::WORD_W-1:0]);
        flags.scan_more  = !match_now && !last_now;
        flags.out_busy   = !out_free;
    end

    // Key memory addressing
    always_comb begin
        if (ctrl.action == dtl_pkg::A_SCAN_INIT) begin
            rd_addr = dtl_pkg::entry_addr(kind_reg, '0);
        end else begin
            rd_addr = dtl_pkg::entry_addr(kind_reg, IW'(cmp_idx_reg + 1'b1));
        end
        wr_addr = dtl_pkg::entry_addr(kind_reg, free_idx_reg);
        mem_we  = commit && (ctrl.action == dtl_pkg::A_RESOLVE) &&
                  !found_reg && have_free_reg;
    end

    // Key memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[wr_addr] <= key_reg;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    // Datapath next state
    always_comb begin
        valid_next     = valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;

        case (ctrl.action)
            dtl_pkg::A_SCAN_INIT: begin
                cmp_idx_next   = '0;
                found_next     = 1'b0;
                have_free_next = 1'b0;
            end
            dtl_pkg::A_SCAN: begin
                cmp_idx_next = IW'(cmp_idx_reg + 1'b1);
                if (match_now) begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                end
                if (!entry_valid_now && !have_free_reg) begin
                    have_free_next = 1'b1;
                    free_idx_next  = cmp_idx_reg;
                end
            end
            dtl_pkg::A_RESOLVE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (found_reg) begin
                        slot_next   = found_idx_reg;
                        hit_next    = 1'b1;
                        status_next = dtl_pkg::ST_OK;
                    end else if (have_free_reg) begin
                        valid_next[wr_addr] = 1'b1;
                        slot_next   = free_idx_reg;
                        hit_next    = 1'b0;
                        status_next = dtl_pkg::ST_OK;
                    end else begin
                        slot_next   = '0;
                        hit_next    = 1'b0;
                        status_next = dtl_pkg::ST_FULL;
                    end
                end
            end
            dtl_pkg::A_ERR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    slot_next     = '0;
                    hit_next      = 1'b0;
                    status_next   = kind_ok ? dtl_pkg::ST_NEG_KEY : dtl_pkg::ST_FULL;
                end
            end
            dtl_pkg::A_RELEASE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    slot_next     = idx_reg;
                    hit_next      = 1'b0;
                    if (rel_valid) begin
                        valid_next[rel_addr] = 1'b0;
                        status_next = dtl_pkg::ST_OK;
                    end else begin
                        status_next = dtl_pkg::ST_FREE_RELEASE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg   <= s_tuser[0];
            kind_reg <= s_tuser[KW:1];
            key_reg  <= s_tdata[dtl_pkg::KEY_W-1:0];
            idx_reg  <= s_tdata[dtl_pkg::KEY_W+IW-1:dtl_pkg::KEY_W];
        end
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        have_free_reg <= have_free_next;
        free_idx_reg  <= free_idx_next;
        slot_reg      <= slot_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
    end

    // Result port
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = dtl_pkg::M_TDATA_W'({status_reg, hit_reg, slot_reg});

endmodule

/* design/dtl_checker.sv */
// Port-level checker for the dedup table unit, bound to the top level.
module dtl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dtl_pkg::M_TDATA_W-1:0] m_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Busy in the cycle after an input transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // A hit is always a clean result
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[6:5] == 2'(dtl_pkg::ST_OK))
        else $error("hit with error status");

    // Full and negative-key results carry slot zero
    a_err_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[6:5] == 2'(dtl_pkg::ST_FULL) ||
                     m_tdata[6:5] == 2'(dtl_pkg::ST_NEG_KEY))
        |-> m_tdata[4:0] == 5'd0)
        else $error("error result with nonzero slot or hit");

endmodule

bind dedup_table_with_lowest_free_slot_unit dtl_checker u_dtl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
